### src/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants for the coverage bitmap tracker: item and
// result layouts, mode codes, and the command passed from front to back.
// ----------------------------------------------------------------------------
package cbt_pkg;

   localparam int ID_W           = 32;
   localparam int MODE_W         = 2;
   localparam int BIT_SEL_W      = 5;
   localparam int WORD_SEL_W     = ID_W - BIT_SEL_W;
   localparam int MAP_WORD_W     = 32;
   localparam int COUNT_W        = 32;
   localparam int EDGE_CNT_W     = 21;
   localparam int STATE_CNT_W    = 17;
   localparam int EDGE_BITS_DEF  = 1048576;
   localparam int STATE_BITS_DEF = 65536;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   item_id;
      logic              last;
   } req_type;

   typedef struct packed {
      logic                   novel;
      logic [COUNT_W-1:0]     novel_inputs;
      logic [EDGE_CNT_W-1:0]  edges_covered;
      logic [STATE_CNT_W-1:0] states_covered;
   } rsp_type;

   typedef struct packed {
      logic                  is_edge;
      logic                  is_state;
      logic [WORD_SEL_W-1:0] word;
      logic [BIT_SEL_W-1:0]  bit_idx;
      logic                  last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

endpackage

### src/coverage_bitmap_tracker.sv
// ----------------------------------------------------------------------------
// coverage_bitmap_tracker
// Records edge and state coverage ids in two bitmaps and reports, per test
// input, whether new coverage was found along with running statistics.
//
//   channel   handshake     payload
//   input     push / full   req_data (mode, item_id, last)
//   result    pop / empty   rsp_data (novel, novel_inputs,
//                                     edges_covered, states_covered)
//
// In the back end each item passes through the registered map word read,
// then the write of the updated word; the next read waits for that write.
// After reset, full stays high while both maps are swept to zero, one word
// per cycle.
// A four-entry command queue decouples intake from the back end; the back
// end holds a last item while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module coverage_bitmap_tracker
   import cbt_pkg::*;
#(
   parameter int EDGE_BITS  = EDGE_BITS_DEF,
   parameter int STATE_BITS = STATE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   q_head_type   head;
   back_ctl_type ctl;

   cbt_front #(.EDGE_BITS(EDGE_BITS), .STATE_BITS(STATE_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .head     (head),
      .ctl      (ctl)
   );

   cbt_back #(.EDGE_BITS(EDGE_BITS), .STATE_BITS(STATE_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .ctl      (ctl),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

### src/cbt_ram.sv
// ----------------------------------------------------------------------------
// cbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/cbt_front.sv
// ----------------------------------------------------------------------------
// cbt_front
// Accepts items, classifies each id against the map sizes and queues the
// resulting command for the back end.
// ----------------------------------------------------------------------------
module cbt_front
   import cbt_pkg::*;
#(
   parameter int EDGE_BITS  = EDGE_BITS_DEF,
   parameter int STATE_BITS = STATE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_type      req_data,
   output q_head_type   head,
   input  back_ctl_type ctl
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        q_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   cmd_type        cmd;
   logic           do_push;
   logic           do_pop;

   always_comb begin
      cmd.is_edge  = (req_data.mode == MODE_EDGE) && (req_data.item_id < ID_W'(EDGE_BITS));
      cmd.is_state = (req_data.mode == MODE_STATE) && (req_data.item_id < ID_W'(STATE_BITS));
      cmd.word     = req_data.item_id[ID_W-1:BIT_SEL_W];
      cmd.bit_idx  = req_data.item_id[BIT_SEL_W-1:0];
      cmd.last     = req_data.last;
   end

   assign full    = (cnt_ff == CW'(QUEUE_DEPTH)) || ctl.clearing;
   assign do_push = push && !full;
   assign do_pop  = ctl.pop;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

`ifndef SYNTH
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      do_pop |-> (cnt_ff != '0))
      else $error("queue popped while empty");
`endif

endmodule

### src/cbt_back.sv
// ----------------------------------------------------------------------------
// cbt_back
// Clears both bitmaps after reset, then carries out one queued command at a
// time: read the map word, set the bit, update counts; last items emit a result.
// ----------------------------------------------------------------------------
module cbt_back
   import cbt_pkg::*;
#(
   parameter int EDGE_BITS  = EDGE_BITS_DEF,
   parameter int STATE_BITS = STATE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  q_head_type   head,
   output back_ctl_type ctl,
   input  logic         pop,
   output logic         empty,
   output rsp_type      rsp_data
);

   localparam int EDGE_WORDS  = (EDGE_BITS + 31) / 32;
   localparam int STATE_WORDS = (STATE_BITS + 31) / 32;
   localparam int MAX_WORDS   = (EDGE_WORDS > STATE_WORDS) ? EDGE_WORDS : STATE_WORDS;
   localparam int EAW = (EDGE_WORDS > 1) ? $clog2(EDGE_WORDS) : 1;
   localparam int SAW = (STATE_WORDS > 1) ? $clog2(STATE_WORDS) : 1;
   localparam int CAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]             st_ff, st_in;
   logic [CAW-1:0]         clr_ff, clr_in;
   cmd_type                cur_ff, cur_in;
   logic                   found_ff, found_in;
   logic [COUNT_W-1:0]     uniq_ff, uniq_in;
   logic [EDGE_CNT_W-1:0]  ecnt_ff, ecnt_in;
   logic [STATE_CNT_W-1:0] scnt_ff, scnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   clearing;
   logic                   upd;
   logic                   issue;
   logic                   clr_edge;
   logic                   clr_state;
   logic [MAP_WORD_W-1:0]  bit_mask;
   logic                   e_new;
   logic                   s_new;
   logic                   found_now;

   logic                   e_we, e_re;
   logic [EAW-1:0]         e_waddr, e_raddr;
   logic [MAP_WORD_W-1:0]  e_wdata, e_rdata;
   logic                   s_we, s_re;
   logic [SAW-1:0]         s_waddr, s_raddr;
   logic [MAP_WORD_W-1:0]  s_wdata, s_rdata;

   assign clearing  = (st_ff == ST_CLEAR);
   assign upd       = (st_ff == ST_UPDATE);
   assign issue     = (st_ff == ST_IDLE) && head.valid && (!head.cmd.last || !rsp_valid_ff);
   assign clr_edge  = {1'b0, clr_ff} < (CAW + 1)'(EDGE_WORDS);
   assign clr_state = {1'b0, clr_ff} < (CAW + 1)'(STATE_WORDS);
   assign bit_mask  = MAP_WORD_W'(1) << cur_ff.bit_idx;
   assign e_new     = upd && cur_ff.is_edge && ((e_rdata & bit_mask) == '0);
   assign s_new     = upd && cur_ff.is_state && ((s_rdata & bit_mask) == '0);
   assign found_now = found_ff || e_new || s_new;

   always_comb begin
      e_we    = clearing ? clr_edge : e_new;
      e_waddr = clearing ? clr_ff[EAW-1:0] : cur_ff.word[EAW-1:0];
      e_wdata = clearing ? '0 : (e_rdata | bit_mask);
      e_re    = issue && head.cmd.is_edge;
      e_raddr = head.cmd.word[EAW-1:0];
      s_we    = clearing ? clr_state : s_new;
      s_waddr = clearing ? clr_ff[SAW-1:0] : cur_ff.word[SAW-1:0];
      s_wdata = clearing ? '0 : (s_rdata | bit_mask);
      s_re    = issue && head.cmd.is_state;
      s_raddr = head.cmd.word[SAW-1:0];
   end

   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      uniq_in      = uniq_ff;
      ecnt_in      = ecnt_ff + EDGE_CNT_W'(e_new);
      scnt_in      = scnt_ff + STATE_CNT_W'(s_new);
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in       = rsp_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CAW'(MAX_WORDS - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (issue) begin
               cur_in = head.cmd;
               st_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            st_in    = ST_IDLE;
            found_in = found_now;
            if (cur_ff.last) begin
               if (found_now && (uniq_ff != '1)) begin
                  uniq_in = uniq_ff + 1'b1;
               end
               rsp_in.novel          = found_now;
               rsp_in.novel_inputs   = uniq_in;
               rsp_in.edges_covered  = ecnt_in;
               rsp_in.states_covered = scnt_in;
               rsp_valid_in          = 1'b1;
               found_in              = 1'b0;
            end
         end
         default: begin
            st_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_ff       <= '0;
         found_ff     <= 1'b0;
         uniq_ff      <= '0;
         ecnt_ff      <= '0;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         found_ff     <= found_in;
         uniq_ff      <= uniq_in;
         ecnt_ff      <= ecnt_in;
         scnt_ff      <= scnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   cbt_ram #(.WIDTH(MAP_WORD_W), .DEPTH(EDGE_WORDS)) u_edge_map (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_en   (e_re),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   cbt_ram #(.WIDTH(MAP_WORD_W), .DEPTH(STATE_WORDS)) u_state_map (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign ctl.pop      = issue;
   assign ctl.clearing = clearing;
   assign empty        = !rsp_valid_ff;
   assign rsp_data     = rsp_ff;

`ifndef SYNTH
   a_no_issue_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !ctl.pop)
      else $error("command taken during clearing pass");
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      (upd && cur_ff.last) |-> !rsp_valid_ff)
      else $error("result overwrites one not yet taken");
   a_edge_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !clearing |=> (ecnt_ff == $past(ecnt_ff))
                 || (ecnt_ff == EDGE_CNT_W'($past(ecnt_ff) + 1'b1)))
      else $error("edge count moved by more than one");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for coverage_bitmap_tracker. A short table of directed
// beats covers map edges, out-of-range ids, empty closes and the unused mode.
// Random test inputs follow, built from repeating, fresh, boundary and
// out-of-range ids. A local copy of both maps predicts each result that the
// table does not give itself, and each popped result is checked field by
// field, under several push/pop throttling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import cbt_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam longint unsigned EDGE_LIMIT  = EDGE_BITS_DEF;
   localparam longint unsigned STATE_LIMIT = STATE_BITS_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_BEATS = 1900;

   typedef struct packed {
      req_type beat;
      logic    typed;
      rsp_type rsp;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   bit                     edge_seen [int unsigned];
   bit                     state_seen [int unsigned];
   logic                   found_new;
   logic [COUNT_W-1:0]     new_inputs;
   logic [EDGE_CNT_W-1:0]  edge_total;
   logic [STATE_CNT_W-1:0] state_total;
   rsp_type                coverage_due [$];
   row_type                directed_rows [$];

   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_stall = 0;
   int beats_sent = 0;

   always #5 clock = ~clock;

   coverage_bitmap_tracker uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic bit track_coverage(input req_type beat, output rsp_type summary);
      summary = '0;
      if (beat.mode == MODE_EDGE && beat.item_id < EDGE_LIMIT
          && !edge_seen.exists(beat.item_id)) begin
         edge_seen[beat.item_id] = 1'b1;
         edge_total++;
         found_new = 1'b1;
      end else if (beat.mode == MODE_STATE && beat.item_id < STATE_LIMIT
                   && !state_seen.exists(beat.item_id)) begin
         state_seen[beat.item_id] = 1'b1;
         state_total++;
         found_new = 1'b1;
      end
      if (!beat.last)
         return 1'b0;
      if (found_new && new_inputs != '1)
         new_inputs++;
      summary.novel          = found_new;
      summary.novel_inputs   = new_inputs;
      summary.edges_covered  = edge_total;
      summary.states_covered = state_total;
      found_new = 1'b0;
      return 1'b1;
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (coverage_due.size() == 0) begin
         $error("result popped with no input closed");
         errors++;
      end else begin
         want = coverage_due.pop_front();
         if (got.novel !== want.novel) begin
            $error("novel: expected %0d, got %0d", want.novel, got.novel);
            errors++;
         end
         if (got.novel_inputs !== want.novel_inputs) begin
            $error("novel_inputs: expected %0d, got %0d",
                   want.novel_inputs, got.novel_inputs);
            errors++;
         end
         if (got.edges_covered !== want.edges_covered) begin
            $error("edges_covered: expected %0d, got %0d",
                   want.edges_covered, got.edges_covered);
            errors++;
         end
         if (got.states_covered !== want.states_covered) begin
            $error("states_covered: expected %0d, got %0d",
                   want.states_covered, got.states_covered);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            check_result(rsp_data);
         pop <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_beat(input req_type beat, input logic typed, input rsp_type typed_rsp);
      rsp_type summary;
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (full);
      beats_sent++;
      if (track_coverage(beat, summary))
         coverage_due.push_back(typed ? typed_rsp : summary);
   endtask

   task automatic add_row(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] item_id,
                          input logic last, input logic typed, input logic nc,
                          input logic [COUNT_W-1:0] ui, input logic [EDGE_CNT_W-1:0] ec,
                          input logic [STATE_CNT_W-1:0] sc);
      row_type row;
      row.beat.mode           = mode;
      row.beat.item_id        = item_id;
      row.beat.last           = last;
      row.typed               = typed;
      row.rsp.novel           = nc;
      row.rsp.novel_inputs    = ui;
      row.rsp.edges_covered   = ec;
      row.rsp.states_covered  = sc;
      directed_rows.push_back(row);
   endtask

   function automatic logic [MODE_W-1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55)
         return MODE_EDGE;
      else if (r < 85)
         return MODE_STATE;
      else if (r < 95)
         return MODE_NONE;
      return MODE_SPARE;
   endfunction

   function automatic logic [ID_W-1:0] pick_id(input logic [MODE_W-1:0] mode);
      logic [ID_W-1:0] limit;
      limit = (mode == MODE_STATE) ? STATE_LIMIT[ID_W-1:0] : EDGE_LIMIT[ID_W-1:0];
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            return $urandom_range(63);
         end
         4: begin
            return limit - 1 - $urandom_range(31);
         end
         5, 6: begin
            return $urandom_range(limit - 1);
         end
         7: begin
            return limit + $urandom_range(31);
         end
         8: begin
            return $urandom();
         end
         default: begin
            return 32'hFFFF_FFFF - $urandom_range(15);
         end
      endcase
   endfunction

   task automatic send_random_input();
      int      len;
      req_type beat;
      rsp_type unused;
      len    = $urandom_range(1, 8);
      unused = '0;
      for (int k = 0; k < len; k++) begin
         beat.mode    = pick_mode();
         beat.item_id = pick_id(beat.mode);
         beat.last    = (k == len - 1);
         send_beat(beat, 1'b0, unused);
      end
   endtask

   task automatic hold_until_drained();
      push <= 1'b0;
      @(posedge clock);
      while (coverage_due.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      found_new   = 1'b0;
      new_inputs  = '0;
      edge_total  = '0;
      state_total = '0;

      add_row(MODE_EDGE,  32'd0,                    1, 1, 1, 1, 1, 0);
      add_row(MODE_EDGE,  32'd0,                    1, 1, 0, 1, 1, 0);
      add_row(MODE_STATE, 32'd0,                    1, 1, 1, 2, 1, 1);
      add_row(MODE_EDGE,  ID_W'(EDGE_LIMIT - 1),    0, 0, 0, 0, 0, 0);
      add_row(MODE_STATE, ID_W'(STATE_LIMIT - 1),   1, 1, 1, 3, 2, 2);
      add_row(MODE_EDGE,  ID_W'(EDGE_LIMIT),        1, 1, 0, 3, 2, 2);
      add_row(MODE_STATE, ID_W'(STATE_LIMIT),       1, 1, 0, 3, 2, 2);
      add_row(MODE_EDGE,  32'hFFFF_FFFF,            1, 1, 0, 3, 2, 2);
      add_row(MODE_STATE, 32'hFFFF_FFFF,            1, 1, 0, 3, 2, 2);
      add_row(MODE_NONE,  32'd0,                    0, 0, 0, 0, 0, 0);
      add_row(MODE_NONE,  32'hFFFF_FFFF,            1, 1, 0, 3, 2, 2);
      add_row(MODE_SPARE, 32'd5,                    1, 1, 0, 3, 2, 2);
      add_row(MODE_EDGE,  32'd31,                   0, 0, 0, 0, 0, 0);
      add_row(MODE_EDGE,  32'd32,                   0, 0, 0, 0, 0, 0);
      add_row(MODE_STATE, 32'd31,                   0, 0, 0, 0, 0, 0);
      add_row(MODE_STATE, 32'd31,                   1, 1, 1, 4, 4, 3);
      add_row(MODE_EDGE,  32'd31,                   0, 0, 0, 0, 0, 0);
      add_row(MODE_NONE,  32'd0,                    1, 1, 0, 4, 4, 3);
      add_row(MODE_EDGE,  32'd1,                    0, 0, 0, 0, 0, 0);
      add_row(MODE_EDGE,  32'd1,                    1, 0, 0, 0, 0, 0);
      add_row(MODE_EDGE,  32'hAAAA_AAAA,            0, 0, 0, 0, 0, 0);
      add_row(MODE_STATE, 32'h5555_5555,            1, 0, 0, 0, 0, 0);
      add_row(MODE_SPARE, 32'hFFFF_FFFF,            0, 0, 0, 0, 0, 0);
      add_row(MODE_STATE, ID_W'(STATE_LIMIT - 2),   1, 0, 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].rsp);
      hold_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle  = 0;
               recv_stall = 0;
            end
            1: begin
               send_idle  = 86;
               recv_stall = 0;
            end
            2: begin
               send_idle  = 0;
               recv_stall = 86;
            end
            default: begin
               send_idle  = 26;
               recv_stall = 26;
            end
         endcase
         while (beats_sent < directed_rows.size() + (phase + 1) * RANDOM_BEATS / 4)
            send_random_input();
         hold_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### files.f
src/cbt_pkg.sv
src/cbt_ram.sv
src/cbt_front.sv
src/cbt_back.sv
src/coverage_bitmap_tracker.sv
bench/tb_top.sv
